// File: design/ipv4p_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ipv4p_pkg;

   typedef enum logic [2:0] {
      ERR_OK     = 3'd0,
      ERR_CHAR   = 3'd1,
      ERR_DIGITS = 3'd2,
      ERR_RANGE  = 3'd3,
      ERR_EMPTY  = 3'd4,
      ERR_DOTS   = 3'd5,
      ERR_MASK   = 3'd6
   } err_type;

   localparam logic [9:0] OCTET_MAX  = 10'd255;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_DOT   = 8'h2E;
   localparam logic [1:0] MAX_DIGITS = 2'd3;
   localparam logic [2:0] MAX_DOTS   = 3'd3;

   // running parse state of the current string
   typedef struct packed {
      logic [9:0]  octet;
      logic [1:0]  digits;
      logic [2:0]  dots;
      err_type     err;
      logic [31:0] shift;
   } parse_type;

   localparam parse_type PARSE_CLEAR = '{
      octet:  10'd0,
      digits: 2'd0,
      dots:   3'd0,
      err:    ERR_OK,
      shift:  32'd0
   };

   typedef struct packed {
      logic        which_string;
      logic [2:0]  error_code;
      logic [31:0] parsed_value;
      logic        address_ok;
      logic [31:0] network_id;
      logic [31:0] host_id;
      logic [31:0] broadcast_addr;
   } rsp_type;

endpackage
`default_nettype wire

// File: design/ipv4p_req_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface ipv4p_req_if;
   logic       valid;
   logic       ready;
   logic       mode;
   logic [7:0] char_code;
   logic       is_final;

   modport source (output valid, output mode, output char_code, output is_final,
                   input ready);
   modport sink (input valid, input mode, input char_code, input is_final,
                 output ready);
endinterface
`default_nettype wire

// File: design/ipv4p_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface ipv4p_rsp_if;
   logic        valid;
   logic        ready;
   logic        which_string;
   logic [2:0]  error_code;
   logic [31:0] parsed_value;
   logic        address_ok;
   logic [31:0] network_id;
   logic [31:0] host_id;
   logic [31:0] broadcast_addr;

   modport source (output valid, output which_string, output error_code,
                   output parsed_value, output address_ok, output network_id,
                   output host_id, output broadcast_addr, input ready);
   modport sink (input valid, input which_string, input error_code,
                 input parsed_value, input address_ok, input network_id,
                 input host_id, input broadcast_addr, output ready);
endinterface
`default_nettype wire

// File: design/ipv4p_char_step.sv
`timescale 1ns / 1ps
`default_nettype none
module ipv4p_char_step (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               step,
   input  wire logic [7:0]         char_code,
   input  wire logic               is_final,
   output ipv4p_pkg::parse_type    parse_next
);

   ipv4p_pkg::parse_type parse_ff;
   ipv4p_pkg::parse_type parse_in;
   logic                 is_digit;
   logic [3:0]           digit;
   logic [9:0]           octet_x10;

   always_comb begin
      is_digit  = (char_code >= ipv4p_pkg::CHAR_ZERO) && (char_code <= ipv4p_pkg::CHAR_NINE);
      digit     = 4'(char_code - ipv4p_pkg::CHAR_ZERO);
      octet_x10 = 10'({parse_ff.octet, 3'b000} + {2'b00, parse_ff.octet, 1'b0});

      parse_next = parse_ff;
      // first error wins: hold state until the final item
      if (parse_ff.err == ipv4p_pkg::ERR_OK) begin
         if (is_digit) begin
            if (parse_ff.digits == ipv4p_pkg::MAX_DIGITS) begin
               parse_next.err = ipv4p_pkg::ERR_DIGITS;
            end else begin
               parse_next.octet  = octet_x10 + {6'd0, digit};
               parse_next.digits = parse_ff.digits + 2'd1;
            end
         end else if (char_code == ipv4p_pkg::CHAR_DOT) begin
            if (parse_ff.digits == 2'd0) begin
               parse_next.err = ipv4p_pkg::ERR_EMPTY;
            end else if (parse_ff.octet > ipv4p_pkg::OCTET_MAX) begin
               parse_next.err = ipv4p_pkg::ERR_RANGE;
            end else if (parse_ff.dots == ipv4p_pkg::MAX_DOTS) begin
               parse_next.err = ipv4p_pkg::ERR_DOTS;
            end else begin
               parse_next.shift  = {parse_ff.shift[23:0], parse_ff.octet[7:0]};
               parse_next.dots   = parse_ff.dots + 3'd1;
               parse_next.octet  = 10'd0;
               parse_next.digits = 2'd0;
            end
         end else begin
            parse_next.err = ipv4p_pkg::ERR_CHAR;
         end
      end

      parse_in = is_final ? ipv4p_pkg::PARSE_CLEAR : parse_next;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         parse_ff <= ipv4p_pkg::PARSE_CLEAR;
      end else if (step) begin
         parse_ff <= parse_in;
      end
   end

endmodule
`default_nettype wire

// File: design/ipv4p_finish.sv
`timescale 1ns / 1ps
`default_nettype none
module ipv4p_finish (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 take,
   input  wire logic                 mode,
   input  wire ipv4p_pkg::parse_type parse_next,
   input  wire logic                 rsp_ready,
   output logic                      rsp_valid,
   output ipv4p_pkg::rsp_type        rsp_data
);

   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   ipv4p_pkg::rsp_type   rsp_ff;
   ipv4p_pkg::rsp_type   rsp_in;
   logic [31:0]          saved_addr_ff;
   logic [31:0]          saved_addr_in;
   logic                 saved_ok_ff;
   logic                 saved_ok_in;
   ipv4p_pkg::err_type   str_err;
   ipv4p_pkg::err_type   fin_err;
   logic [31:0]          value;
   logic [31:0]          inv;
   logic                 contiguous;

   always_comb begin
      // close the last octet, then the dot count
      str_err = parse_next.err;
      if (str_err == ipv4p_pkg::ERR_OK) begin
         if (parse_next.digits == 2'd0) begin
            str_err = ipv4p_pkg::ERR_EMPTY;
         end else if (parse_next.octet > ipv4p_pkg::OCTET_MAX) begin
            str_err = ipv4p_pkg::ERR_RANGE;
         end else if (parse_next.dots != ipv4p_pkg::MAX_DOTS) begin
            str_err = ipv4p_pkg::ERR_DOTS;
         end
      end

      value = (str_err == ipv4p_pkg::ERR_OK) ?
              {parse_next.shift[23:0], parse_next.octet[7:0]} : 32'd0;
      inv        = ~value;
      contiguous = ((inv & (inv + 32'd1)) == 32'd0);

      fin_err       = str_err;
      saved_addr_in = saved_addr_ff;
      saved_ok_in   = saved_ok_ff;
      rsp_in        = '0;
      rsp_in.which_string = mode;

      if (!mode) begin
         saved_addr_in = value;
         saved_ok_in   = (str_err == ipv4p_pkg::ERR_OK);
         rsp_in.parsed_value = value;
      end else begin
         if ((str_err == ipv4p_pkg::ERR_OK) && !contiguous) begin
            fin_err = ipv4p_pkg::ERR_MASK;
         end
         if (fin_err == ipv4p_pkg::ERR_OK) begin
            rsp_in.parsed_value   = value;
            rsp_in.network_id     = saved_addr_ff & value;
            rsp_in.host_id        = saved_addr_ff & ~value;
            rsp_in.broadcast_addr = (saved_addr_ff & value) | ~value;
         end
      end
      rsp_in.error_code = fin_err;
      rsp_in.address_ok = saved_ok_in;

      rsp_valid_in = take | (rsp_valid_ff & ~rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         saved_addr_ff <= 32'd0;
         saved_ok_ff   <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (take) begin
            saved_addr_ff <= saved_addr_in;
            saved_ok_ff   <= saved_ok_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

// File: design/ipv4_dotted_text_subnet_parser.sv
// A final character waits in the input register until the result register is free;
// its result is then registered there and offered on the response.
// Throughput: one character per cycle; the input register is refilled while a
// finished result waits, and only a final character needs, and may wait on, the result register.
// Rate is set by the combinational accumulate and mask check after the input register.
// Reset (synchronous): clears valids, the parse state and the stored address.
`timescale 1ns / 1ps
`default_nettype none
module ipv4_dotted_text_subnet_parser (
   input  wire logic    clock,
   input  wire logic    reset,
   ipv4p_req_if.sink    req,
   ipv4p_rsp_if.source  rsp
);

   logic                 s1_valid_ff;
   logic                 s1_valid_in;
   logic                 s1_mode_ff;
   logic [7:0]           s1_char_ff;
   logic                 s1_fin_ff;
   logic                 out_free;
   logic                 advance;
   logic                 req_take;
   logic                 out_valid;
   ipv4p_pkg::parse_type parse_next;
   ipv4p_pkg::rsp_type   out_data;

   always_comb begin
      out_free    = !out_valid || rsp.ready;
      // a non-final item produces no result, so it never waits on the output
      advance     = s1_valid_ff && (!s1_fin_ff || out_free);
      req.ready   = !s1_valid_ff || advance;
      req_take    = req.valid && req.ready;
      s1_valid_in = req_take || (s1_valid_ff && !advance);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_mode_ff <= req.mode;
         s1_char_ff <= req.char_code;
         s1_fin_ff  <= req.is_final;
      end
   end

   ipv4p_char_step u_char_step (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .char_code  (s1_char_ff),
      .is_final   (s1_fin_ff),
      .parse_next (parse_next)
   );

   ipv4p_finish u_finish (
      .clock      (clock),
      .reset      (reset),
      .take       (advance && s1_fin_ff),
      .mode       (s1_mode_ff),
      .parse_next (parse_next),
      .rsp_ready  (rsp.ready),
      .rsp_valid  (out_valid),
      .rsp_data   (out_data)
   );

   assign rsp.valid          = out_valid;
   assign rsp.which_string   = out_data.which_string;
   assign rsp.error_code     = out_data.error_code;
   assign rsp.parsed_value   = out_data.parsed_value;
   assign rsp.address_ok     = out_data.address_ok;
   assign rsp.network_id     = out_data.network_id;
   assign rsp.host_id        = out_data.host_id;
   assign rsp.broadcast_addr = out_data.broadcast_addr;

endmodule
`default_nettype wire
